// ===== rtl/dpwc_pkg.sv =====
package dpwc_pkg;

   // Field and counter widths
   localparam int LEVEL_W    = 1;
   localparam int HIGH_CFG_W = 12;
   localparam int LOW_CFG_W  = 16;
   localparam int RUN_W      = 18;
   localparam int WIDTH_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Lane count
   localparam int CHANNELS_DEF = 2;
   localparam int CHANNELS_MAX = 8;

   // Register reset values
   localparam logic [HIGH_CFG_W-1:0] MIN_HIGH_RST    = 12'd70;
   localparam logic [HIGH_CFG_W-1:0] MAX_HIGH_RST    = 12'd220;
   localparam logic [LOW_CFG_W-1:0]  LOW_TIMEOUT_RST = 16'd2500;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_HIGH    = 2'd0,
      CSR_MAX_HIGH    = 2'd1,
      CSR_LOW_TIMEOUT = 2'd2
   } csr_idx_type;

   // Thresholds shared by every lane
   typedef struct packed {
      logic [HIGH_CFG_W-1:0] min_high;
      logic [HIGH_CFG_W-1:0] max_high;
      logic [LOW_CFG_W-1:0]  low_timeout;
   } cfg_type;

   // What one lane reports after its update
   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic               valid;
   } lane_out_type;

endpackage

// ===== rtl/dual_pulse_width_capture_unit.sv =====
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_level_ch0, req_level_ch1
// rsp       out        rsp_valid / rsp_ready   rsp_width_ch0/1, rsp_valid_ch0/1
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// One item per cycle while the output register is free: every lane updates its
// counter in the accept cycle and the merged result sits in the output register in the next cycle.
// req_ready is high whenever the output register is empty or drained in the
// same cycle, so a stalled result blocks every new item until it is taken.
// Synchronous reset clears every lane and the register file to its defaults.
// csr_ready is always high; writes land in the register file in the next cycle.
module dual_pulse_width_capture_unit
   import dpwc_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_level_ch0,
   input  logic                  req_level_ch1,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WIDTH_W-1:0]    rsp_width_ch0,
   output logic [WIDTH_W-1:0]    rsp_width_ch1,
   output logic                  rsp_valid_ch0,
   output logic                  rsp_valid_ch1,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type                     cfg_ff, cfg_in;
   logic                        accept;
   logic                        out_free;
   lane_out_type [CHANNELS-1:0] lanes;

   // Register file writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_HIGH:    cfg_in.min_high    = csr_data[HIGH_CFG_W-1:0];
            CSR_MAX_HIGH:    cfg_in.max_high    = csr_data[HIGH_CFG_W-1:0];
            CSR_LOW_TIMEOUT: cfg_in.low_timeout = csr_data[LOW_CFG_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_high    <= MIN_HIGH_RST;
         cfg_ff.max_high    <= MAX_HIGH_RST;
         cfg_ff.low_timeout <= LOW_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = out_free;
   assign accept    = req_valid && out_free;

   // One lane per channel; lanes past the two inputs see a low level
   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      logic lane_level;
      if (g == 0) begin : g_l0
         assign lane_level = req_level_ch0;
      end else if (g == 1) begin : g_l1
         assign lane_level = req_level_ch1;
      end else begin : g_lx
         assign lane_level = 1'b0;
      end

      dpwc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .advance   (accept),
         .level     (lane_level),
         .cfg       (cfg_ff),
         .lane_next (lanes[g])
      );
   end

   // Merge lanes into the output register
   dpwc_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .lanes         (lanes),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .out_free      (out_free),
      .rsp_width_ch0 (rsp_width_ch0),
      .rsp_width_ch1 (rsp_width_ch1),
      .rsp_valid_ch0 (rsp_valid_ch0),
      .rsp_valid_ch1 (rsp_valid_ch1)
   );

   // An accepted item always yields a result next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // A stalled result blocks new items
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted over a stalled result");

   // A low sample never leaves channel zero marked valid
   a_low_clears_valid: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_level_ch0 |=> !rsp_valid_ch0)
      else $error("channel zero valid after a low sample");

endmodule

// ===== rtl/dpwc_lane.sv =====
module dpwc_lane
   import dpwc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         level,
   input  cfg_type      cfg,
   output lane_out_type lane_next
);

   logic signed [RUN_W-1:0] run_count_ff, run_count_in;
   logic                    pulse_valid_ff, pulse_valid_in;
   logic [WIDTH_W-1:0]      width_ff, width_in;

   logic signed [RUN_W-1:0] hi_run;
   logic signed [RUN_W-1:0] lo_run;
   logic signed [RUN_W-1:0] min_s;
   logic signed [RUN_W-1:0] max_s;
   logic signed [RUN_W-1:0] low_limit;

   // Thresholds as signed counts
   assign min_s     = $signed({{(RUN_W-HIGH_CFG_W){1'b0}}, cfg.min_high});
   assign max_s     = $signed({{(RUN_W-HIGH_CFG_W){1'b0}}, cfg.max_high});
   assign low_limit = -$signed({{(RUN_W-LOW_CFG_W){1'b0}}, cfg.low_timeout});

   // Extend the high run, or start one after a low run
   assign hi_run = (run_count_ff[RUN_W-1] ? '0 : run_count_ff) + RUN_W'(1);

   // Extend the low run, or start one after a high run
   assign lo_run = ((!run_count_ff[RUN_W-1] && run_count_ff != '0) ? '0 : run_count_ff)
                   - RUN_W'(1);

   // Update the run counter, valid mark and width
   always_comb begin
      run_count_in   = run_count_ff;
      pulse_valid_in = pulse_valid_ff;
      width_in       = width_ff;
      if (level) begin
         run_count_in = hi_run;
         if (hi_run > min_s) begin
            pulse_valid_in = 1'b1;
         end
         if (hi_run > max_s) begin
            pulse_valid_in = 1'b0;
            run_count_in   = '0;
            width_in       = '0;
         end
      end else if (pulse_valid_ff) begin
         // falling edge of a valid pulse: latch its length
         pulse_valid_in = 1'b0;
         width_in       = run_count_ff[WIDTH_W-1:0];
         run_count_in   = '0;
      end else begin
         run_count_in = lo_run;
         if (lo_run < low_limit) begin
            width_in     = '0;
            run_count_in = '0;
         end
      end
   end

   // Advance the lane on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff   <= '0;
         pulse_valid_ff <= 1'b0;
         width_ff       <= '0;
      end else if (advance) begin
         run_count_ff   <= run_count_in;
         pulse_valid_ff <= pulse_valid_in;
         width_ff       <= width_in;
      end
   end

   assign lane_next.width = width_in;
   assign lane_next.valid = pulse_valid_in;

endmodule

// ===== rtl/dpwc_merge.sv =====
module dpwc_merge
   import dpwc_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  lane_out_type [CHANNELS-1:0] lanes,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       out_free,
   output logic [WIDTH_W-1:0]         rsp_width_ch0,
   output logic [WIDTH_W-1:0]         rsp_width_ch1,
   output logic                       rsp_valid_ch0,
   output logic                       rsp_valid_ch1
);

   logic         rsp_valid_ff, rsp_valid_in;
   lane_out_type ch0_ff, ch0_in;
   lane_out_type ch1_ff, ch1_in;

   // Pick the two reported lanes; a missing lane reads as zero
   always_comb begin
      ch0_in = '0;
      ch1_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (i == 0) begin
            ch0_in = lanes[i];
         end
         if (i == 1) begin
            ch1_in = lanes[i];
         end
      end
   end

   // Output register is free when empty or being drained
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload on each accepted item
   always_ff @(posedge clock) begin
      if (advance) begin
         ch0_ff <= ch0_in;
         ch1_ff <= ch1_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_width_ch0 = ch0_ff.width;
   assign rsp_width_ch1 = ch1_ff.width;
   assign rsp_valid_ch0 = ch0_ff.valid;
   assign rsp_valid_ch1 = ch1_ff.valid;

endmodule
